// ----- src/ole_pkg.sv -----
// Shared types and constants for the ordered list engine.
// No dependencies; imported by the interfaces, the cell and the top level.
`timescale 1ns / 1ps

package ole_pkg;

    localparam int OP_W   = 4;
    localparam int ITEM_W = 32;
    localparam int POS_W  = 8;
    localparam int FIDX_W = 9;
    localparam int ST_W   = 2;
    localparam int ECNT_W = 8;

    // found_index value when nothing was found (-1)
    localparam logic signed [FIDX_W-1:0] FIDX_NONE = '1;

    typedef enum logic [OP_W-1:0] {
        OP_ADD_FRONT = 4'd0,
        OP_ADD_BACK  = 4'd1,
        OP_ADD_AT    = 4'd2,
        OP_REM_FRONT = 4'd3,
        OP_REM_BACK  = 4'd4,
        OP_REM_AT    = 4'd5,
        OP_REM_VALUE = 4'd6,
        OP_FIND      = 4'd7,
        OP_CLEAR     = 4'd8
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_DONE = 2'd0,
        ST_ZERO = 2'd1,
        ST_FULL = 2'd2,
        ST_NONE = 2'd3
    } status_t;

    // What every cell of the row does in a given cycle
    typedef enum logic [1:0] {
        CM_HOLD,
        CM_CMP,
        CM_INSERT,
        CM_REMOVE
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t          mode;
        logic [ITEM_W-1:0]   item;
    } cell_ctl_t;

endpackage

// ----- src/ole_req_if.sv -----
// Request channel: valid/ready handshake carrying one operation.
// Depends on ole_pkg.
`timescale 1ns / 1ps

interface ole_req_if;
    import ole_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [ITEM_W-1:0] item;
    logic [POS_W-1:0]  position;

    modport source (output valid, output operation, output item, output position,
                    input ready);
    modport sink   (input valid, input operation, input item, input position,
                    output ready);
endinterface

// ----- src/ole_rsp_if.sv -----
// Response channel: valid/ready handshake carrying one operation result.
// Depends on ole_pkg.
`timescale 1ns / 1ps

interface ole_rsp_if;
    import ole_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [ITEM_W-1:0]        returned_item;
    logic signed [FIDX_W-1:0] found_index;
    logic [ST_W-1:0]          status;
    logic [ECNT_W-1:0]        entry_count;

    modport source (output valid, output returned_item, output found_index,
                    output status, output entry_count, input ready);
    modport sink   (input valid, input returned_item, input found_index,
                    input status, input entry_count, output ready);
endinterface

// ----- src/ole_cell.sv -----
// One slot of the list row: holds a handle, compares it, shifts left or right.
// Depends on ole_pkg.
`timescale 1ns / 1ps

module ole_cell #(
    parameter int IDX_W = 4,
    parameter int CNT_W = 5
) (
    input  logic                      clk,
    input  ole_pkg::cell_ctl_t        ctl,
    input  logic [IDX_W-1:0]          idx,
    input  logic [IDX_W-1:0]          tgt,
    input  logic [CNT_W-1:0]          count,
    input  logic [ole_pkg::ITEM_W-1:0] left_slot,
    input  logic [ole_pkg::ITEM_W-1:0] right_slot,
    input  logic                      seen_in,
    output logic                      seen_out,
    output logic                      first,
    output logic [ole_pkg::ITEM_W-1:0] slot,
    output logic [ole_pkg::ITEM_W-1:0] pick
);
    import ole_pkg::*;

    logic [ITEM_W-1:0] slot_reg;
    logic              match_reg;
    logic              live;
    logic              hit;
    logic              after;

    // position of this cell relative to the count and the target
    always_comb
    begin
        live  = CNT_W'(idx) < count;
        hit   = idx == tgt;
        after = idx > tgt;
    end

    // compare, insert (shift towards the back) or remove (shift towards the front)
    always_ff @(posedge clk)
    begin
        unique case (ctl.mode)
            CM_CMP:
            begin
                match_reg <= live && (slot_reg == ctl.item);
            end
            CM_INSERT:
            begin
                if (hit)
                    slot_reg <= ctl.item;
                else if (after)
                    slot_reg <= left_slot;
            end
            CM_REMOVE:
            begin
                if (hit || after)
                    slot_reg <= right_slot;
            end
            CM_HOLD:
            begin
            end
        endcase
    end

    // first-match ripple and read-out
    assign first    = match_reg & ~seen_in;
    assign seen_out = seen_in | match_reg;
    assign slot     = slot_reg;
    assign pick     = hit ? slot_reg : '0;

endmodule

// ----- src/ordered_list_engine.sv -----
// Ordered list engine: a deque of up to CAPACITY nonzero 32-bit handles held in a
// row of cells, index 0 at the front. Each operation passes through four steps
// from acceptance to a registered result: capture, a compare step in which every
// cell compares its handle, an encode step that ripples the first match along the
// row and plans the change, and an apply step in which the row shifts and the
// result is loaded. A new request is accepted once the previous one has reached
// the output register; the apply step waits while that register is still full
// and not being taken. Depends on ole_pkg, the channel interfaces and ole_cell.
`timescale 1ns / 1ps

module ordered_list_engine #(
    parameter int CAPACITY = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    ole_req_if.sink   req,
    ole_rsp_if.source rsp
);
    import ole_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_ENC,
        S_APPLY
    } state_t;

    state_t                   state_reg;
    logic [OP_W-1:0]          op_reg;
    logic [ITEM_W-1:0]        item_reg;
    logic [POS_W-1:0]         pos_reg;
    logic [CNT_W-1:0]         count_reg;
    // plan made in the encode cycle
    cell_mode_t               act_reg;
    logic [IDX_W-1:0]         tgt_reg;
    status_t                  st_reg;
    logic signed [FIDX_W-1:0] fidx_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     take_reg;
    // output register
    logic                     rsp_valid_reg;
    logic [ITEM_W-1:0]        ret_reg;
    logic signed [FIDX_W-1:0] rsp_fidx_reg;
    status_t                  rsp_st_reg;
    logic [CNT_W-1:0]         rsp_cnt_reg;

    // plan, next values
    cell_mode_t               act_next;
    logic [IDX_W-1:0]         tgt_next;
    status_t                  st_next;
    logic signed [FIDX_W-1:0] fidx_next;
    logic [CNT_W-1:0]         cnt_next;
    logic                     take_next;

    cell_ctl_t                ctl;
    logic                     load;
    logic [CAPACITY-1:0]      first_vec;
    logic [CAPACITY:0]        seen;
    logic [ITEM_W-1:0]        slot_vec [CAPACITY];
    logic [ITEM_W-1:0]        pick_vec [CAPACITY];
    logic [IDX_W-1:0]         first_idx;
    logic [ITEM_W-1:0]        picked;
    logic                     found;
    logic                     is_full;
    logic                     is_empty;
    logic                     pos_past;

    assign req.ready = (state_reg == S_IDLE);
    assign load      = (state_reg == S_APPLY) && (!rsp_valid_reg || rsp.ready);

    // broadcast to the row
    always_comb
    begin
        ctl.item = item_reg;
        priority if (load)
            ctl.mode = act_reg;
        else if (state_reg == S_CMP)
            ctl.mode = CM_CMP;
        else
            ctl.mode = CM_HOLD;
    end

    // row of cells
    assign seen[0] = 1'b0;
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        ole_cell #(
            .IDX_W (IDX_W),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .idx        (IDX_W'(i)),
            .tgt        (tgt_reg),
            .count      (count_reg),
            .left_slot  ((i == 0) ? item_reg : slot_vec[(i == 0) ? 0 : i - 1]),
            .right_slot ((i == CAPACITY - 1) ? slot_vec[i]
                                             : slot_vec[(i == CAPACITY - 1) ? i : i + 1]),
            .seen_in    (seen[i]),
            .seen_out   (seen[i+1]),
            .first      (first_vec[i]),
            .slot       (slot_vec[i]),
            .pick       (pick_vec[i])
        );
    end

    // one-hot first match and target slot read as AND-OR over the row
    always_comb
    begin
        first_idx = '0;
        picked    = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            first_idx = first_idx | (first_vec[i] ? IDX_W'(i) : '0);
            picked    = picked | pick_vec[i];
        end
    end

    assign found    = seen[CAPACITY] && (item_reg != '0);
    assign is_full  = count_reg == CNT_W'(CAPACITY);
    assign is_empty = count_reg == '0;
    assign pos_past = {1'b0, pos_reg} >= (POS_W + 1)'(count_reg);

    // plan the operation
    always_comb
    begin
        act_next  = CM_HOLD;
        tgt_next  = '0;
        st_next   = ST_DONE;
        fidx_next = FIDX_NONE;
        cnt_next  = count_reg;
        take_next = 1'b0;
        unique case (op_reg)
            OP_ADD_FRONT, OP_ADD_BACK, OP_ADD_AT:
            begin
                priority if (item_reg == '0)
                    st_next = ST_ZERO;
                else if (is_full)
                    st_next = ST_FULL;
                else
                begin
                    act_next = CM_INSERT;
                    cnt_next = count_reg + 1'b1;
                    priority if (op_reg == OP_ADD_FRONT)
                        tgt_next = '0;
                    else if (op_reg == OP_ADD_BACK || pos_past)
                        tgt_next = IDX_W'(count_reg);
                    else
                        tgt_next = IDX_W'(pos_reg);
                end
            end
            OP_REM_FRONT, OP_REM_BACK:
            begin
                if (is_empty)
                    st_next = ST_NONE;
                else
                begin
                    act_next  = CM_REMOVE;
                    take_next = 1'b1;
                    cnt_next  = count_reg - 1'b1;
                    tgt_next  = (op_reg == OP_REM_FRONT) ? '0
                                                         : IDX_W'(count_reg - 1'b1);
                end
            end
            OP_REM_AT:
            begin
                if (pos_past)
                    st_next = ST_NONE;
                else
                begin
                    act_next  = CM_REMOVE;
                    take_next = 1'b1;
                    cnt_next  = count_reg - 1'b1;
                    tgt_next  = IDX_W'(pos_reg);
                end
            end
            OP_REM_VALUE:
            begin
                if (!found)
                    st_next = ST_NONE;
                else
                begin
                    act_next  = CM_REMOVE;
                    take_next = 1'b1;
                    cnt_next  = count_reg - 1'b1;
                    tgt_next  = first_idx;
                end
            end
            OP_FIND:
            begin
                if (!found)
                    st_next = ST_NONE;
                else
                    fidx_next = FIDX_W'(first_idx);
            end
            OP_CLEAR:
            begin
                cnt_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    // sequencer, plan and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            op_reg        <= '0;
            item_reg      <= '0;
            pos_reg       <= '0;
            act_reg       <= CM_HOLD;
            tgt_reg       <= '0;
            st_reg        <= ST_DONE;
            fidx_reg      <= FIDX_NONE;
            cnt_reg       <= '0;
            take_reg      <= 1'b0;
            ret_reg       <= '0;
            rsp_fidx_reg  <= FIDX_NONE;
            rsp_st_reg    <= ST_DONE;
            rsp_cnt_reg   <= '0;
        end
        else
        begin
            // result valid: set on load, cleared once the sink takes it
            if (load)
                rsp_valid_reg <= 1'b1;
            else if (rsp_valid_reg && rsp.ready)
                rsp_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        op_reg    <= req.operation;
                        item_reg  <= req.item;
                        pos_reg   <= req.position;
                        state_reg <= S_CMP;
                    end
                end
                S_CMP:
                begin
                    state_reg <= S_ENC;
                end
                S_ENC:
                begin
                    act_reg   <= act_next;
                    tgt_reg   <= tgt_next;
                    st_reg    <= st_next;
                    fidx_reg  <= fidx_next;
                    cnt_reg   <= cnt_next;
                    take_reg  <= take_next;
                    state_reg <= S_APPLY;
                end
                S_APPLY:
                begin
                    if (load)
                    begin
                        ret_reg       <= take_reg ? picked : '0;
                        rsp_fidx_reg  <= fidx_reg;
                        rsp_st_reg    <= st_reg;
                        rsp_cnt_reg   <= cnt_reg;
                        count_reg     <= cnt_reg;
                        state_reg     <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.returned_item = ret_reg;
    assign rsp.found_index   = rsp_fidx_reg;
    assign rsp.status        = rsp_st_reg;
    assign rsp.entry_count   = ECNT_W'(rsp_cnt_reg);

`ifndef ASSERT_OFF
    // the count never runs past the capacity
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // at most one cell claims the first match when the row is encoded
    a_first_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ENC) |-> $onehot0(first_vec))
        else $error("more than one first match in the row");

    // a result only appears from the apply cycle
    a_rsp_from_apply: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_APPLY))
        else $error("result loaded outside the apply cycle");

    // a full status is only reported against a full row
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (load && st_reg == ST_FULL) |-> is_full)
        else $error("full status with room left");

    // a removal always takes one entry away
    a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
        (load && act_reg == CM_REMOVE) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("removal did not lower the count by one");
`endif

endmodule
